/* rtl/sqt_pkg.sv */
// Shared types and codes for the stack and ring queue block.
package sqt_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [2:0] OP_ENQ  = 3'd0;
    localparam logic [2:0] OP_PUSH = 3'd1;
    localparam logic [2:0] OP_POP  = 3'd2;
    localparam logic [2:0] OP_XFER = 3'd3;
    localparam logic [2:0] OP_DEQ  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_QFULL = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SFULL = 2'd3;

    localparam logic REG_CAP = 1'b0;
    localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [2:0]         op;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        logic [1:0]         status;
        logic [COUNT_W-1:0] queue_count;
        logic [COUNT_W-1:0] stack_count;
        logic [COUNT_W-1:0] dropped_count;
    } t_res;

endpackage

/* rtl/stack_and_ring_queue_with_transfer_top.sv */
// Top level of the ring queue and bounded stack with stack-to-queue transfer.
//
//   Channel    Handshake                         Payload
//   request    start in, busy out                i_req (op, value)
//   result     o_res_valid out, one cycle        o_res (value, status, counts)
//   config     psel/penable/pwrite, pready = 1   paddr, pwdata, prdata
//
// Enqueue, push and unknown operations give their result from the execute state;
// pop and dequeue pass through a read-wait state, as the memory read is registered.
// A transfer moves the stack entries into the queue in its own transfer state,
// since the stack memory delivers one entry per cycle into the queue memory.
// Reset is synchronous and empties both stores; no clearing pass is needed.
// Busy is low in the cycle that shows a result; the receiver cannot stall it.
module stack_and_ring_queue_with_transfer_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sqt_pkg::t_req               i_req,
    output sqt_pkg::t_res               o_res,
    output logic                        o_res_valid,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqt_pkg::APB_AW-1:0]  paddr,
    input  logic [sqt_pkg::APB_DW-1:0]  pwdata,
    output logic [sqt_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import sqt_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    logic [QCW-1:0]        w_cap;
    logic                  w_clear;
    logic                  w_q_we;
    logic [QAW-1:0]        w_q_waddr;
    logic [DATA_WIDTH-1:0] w_q_wdata;
    logic [QAW-1:0]        w_q_raddr;
    logic [DATA_WIDTH-1:0] w_q_rdata;
    logic                  w_s_we;
    logic [SAW-1:0]        w_s_waddr;
    logic [DATA_WIDTH-1:0] w_s_wdata;
    logic [SAW-1:0]        w_s_raddr;
    logic [DATA_WIDTH-1:0] w_s_rdata;

    sqt_cfg #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cap   (w_cap),
        .o_clear (w_clear)
    );

    sqt_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_cap       (w_cap),
        .i_clear     (w_clear),
        .o_q_we      (w_q_we),
        .o_q_waddr   (w_q_waddr),
        .o_q_wdata   (w_q_wdata),
        .o_q_raddr   (w_q_raddr),
        .i_q_rdata   (w_q_rdata),
        .o_s_we      (w_s_we),
        .o_s_waddr   (w_s_waddr),
        .o_s_wdata   (w_s_wdata),
        .o_s_raddr   (w_s_raddr),
        .i_s_rdata   (w_s_rdata)
    );

    sqt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    sqt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (w_s_wdata),
        .i_raddr (w_s_raddr),
        .o_rdata (w_s_rdata)
    );

endmodule

/* rtl/sqt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sqt_cfg.sv */
// Configuration register file holding the queue capacity.
module sqt_cfg #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sqt_pkg::APB_AW-1:0]         paddr,
    input  logic [sqt_pkg::APB_DW-1:0]         pwdata,
    output logic [sqt_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_cap,
    output logic                               o_clear
);
    import sqt_pkg::*;

    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_RST = (QUEUE_DEPTH < 64) ? QUEUE_DEPTH : 64;

    logic [COUNT_W-1:0] r_cap_raw;
    logic [QCW-1:0]     r_cap_eff;
    logic [QCW-1:0]     n_cap_eff;
    logic [COUNT_W-1:0] w_raw;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == REG_CAP);
    assign w_raw  = pwdata[COUNT_W-1:0];

    always_comb begin
        if (w_raw == '0) begin
            n_cap_eff = QCW'(1);
        end else if (int'(w_raw) > QUEUE_DEPTH) begin
            n_cap_eff = QCW'(QUEUE_DEPTH);
        end else begin
            n_cap_eff = QCW'(w_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_raw <= CAP_RESET;
            r_cap_eff <= QCW'(CAP_RST);
        end else if (w_wr) begin
            r_cap_raw <= w_raw;
            r_cap_eff <= n_cap_eff;
        end
    end

    assign prdata  = (paddr[2] == REG_CAP) ? APB_DW'(r_cap_raw) : '0;
    assign o_cap   = r_cap_eff;
    assign o_clear = w_wr;

endmodule

/* rtl/sqt_ctrl.sv */
// Sequencer that reads, updates and writes the queue and stack memories.
module sqt_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  sqt_pkg::t_req                      i_req,
    output logic                               o_busy,
    output sqt_pkg::t_res                      o_res,
    output logic                               o_res_valid,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_cap,
    input  logic                               i_clear,
    output logic                               o_q_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_q_waddr,
    output logic [DATA_WIDTH-1:0]              o_q_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_q_raddr,
    input  logic [DATA_WIDTH-1:0]              i_q_rdata,
    output logic                               o_s_we,
    output logic [$clog2(STACK_DEPTH)-1:0]     o_s_waddr,
    output logic [DATA_WIDTH-1:0]              o_s_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0]     o_s_raddr,
    input  logic [DATA_WIDTH-1:0]              i_s_rdata
);
    import sqt_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam logic [SCW-1:0] S_MAX = SCW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_XFER   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [2:0]          r_op, n_op;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [QAW-1:0]      r_qhead, n_qhead;
    logic [QAW-1:0]      r_qtail, n_qtail;
    logic [QCW-1:0]      r_qfill, n_qfill;
    logic [SCW-1:0]      r_sfill, n_sfill;
    logic [SCW-1:0]      r_drop, n_drop;
    logic                r_pend, n_pend;
    t_res                r_res, n_res;
    logic                r_res_valid, n_res_valid;

    logic                w_q_ok;
    logic                w_put;
    logic [DATA_WIDTH-1:0] w_put_data;
    logic                w_finish;
    logic [VALUE_W-1:0]  w_out;
    logic [1:0]          w_status;
    logic [SCW-1:0]      w_drop_out;
    logic [QAW-1:0]      w_tail_inc;
    logic [QAW-1:0]      w_head_inc;

    assign w_q_ok = (r_qfill < i_cap);
    assign w_tail_inc = ((QCW+1)'(r_qtail) + (QCW+1)'(1) == (QCW+1)'(i_cap)) ?
                        '0 : r_qtail + QAW'(1);
    assign w_head_inc = ((QCW+1)'(r_qhead) + (QCW+1)'(1) == (QCW+1)'(i_cap)) ?
                        '0 : r_qhead + QAW'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_qhead     = r_qhead;
        n_qtail     = r_qtail;
        n_qfill     = r_qfill;
        n_sfill     = r_sfill;
        n_drop      = r_drop;
        n_pend      = r_pend;
        n_res       = r_res;
        n_res_valid = 1'b0;
        w_put       = 1'b0;
        w_put_data  = r_val;
        w_finish    = 1'b0;
        w_out       = '0;
        w_status    = ST_OK;
        w_drop_out  = '0;
        o_q_we      = 1'b0;
        o_q_waddr   = r_qtail;
        o_q_wdata   = r_val;
        o_q_raddr   = r_qhead;
        o_s_we      = 1'b0;
        o_s_waddr   = r_sfill[SAW-1:0];
        o_s_wdata   = r_val;
        o_s_raddr   = SAW'(r_sfill - SCW'(1));

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_req.op;
                    n_val   = DATA_WIDTH'(i_req.value);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ENQ: begin
                        w_put    = 1'b1;
                        w_status = w_q_ok ? ST_OK : ST_QFULL;
                        w_finish = 1'b1;
                    end
                    OP_PUSH: begin
                        if (r_sfill < S_MAX) begin
                            o_s_we  = 1'b1;
                            n_sfill = r_sfill + SCW'(1);
                        end else begin
                            w_status = ST_SFULL;
                        end
                        w_finish = 1'b1;
                    end
                    OP_POP: begin
                        if (r_sfill == '0) begin
                            w_status = ST_EMPTY;
                            w_finish = 1'b1;
                        end else begin
                            n_sfill = r_sfill - SCW'(1);
                            n_state = S_RDWAIT;
                        end
                    end
                    OP_XFER: begin
                        n_drop  = '0;
                        n_pend  = 1'b0;
                        n_state = S_XFER;
                    end
                    OP_DEQ: begin
                        if (r_qfill == '0) begin
                            w_status = ST_EMPTY;
                            w_finish = 1'b1;
                        end else begin
                            n_qhead = w_head_inc;
                            n_qfill = r_qfill - QCW'(1);
                            n_state = S_RDWAIT;
                        end
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
            end
            S_RDWAIT: begin
                w_out    = VALUE_W'((r_op == OP_POP) ? i_s_rdata : i_q_rdata);
                w_finish = 1'b1;
            end
            S_XFER: begin
                if (r_pend) begin
                    w_put      = 1'b1;
                    w_put_data = i_s_rdata;
                    if (!w_q_ok) begin
                        n_drop = r_drop + SCW'(1);
                    end
                end
                if (r_sfill != '0) begin
                    n_sfill = r_sfill - SCW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_sfill == '0 && !r_pend) begin
                    w_drop_out = r_drop;
                    w_status   = (r_drop != '0) ? ST_QFULL : ST_OK;
                    w_finish   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_put && w_q_ok) begin
            o_q_we    = 1'b1;
            o_q_wdata = w_put_data;
            n_qtail   = w_tail_inc;
            n_qfill   = r_qfill + QCW'(1);
        end

        if (w_finish) begin
            n_res.out_value     = w_out;
            n_res.status        = w_status;
            n_res.queue_count   = COUNT_W'(n_qfill);
            n_res.stack_count   = COUNT_W'(n_sfill);
            n_res.dropped_count = COUNT_W'(w_drop_out);
            n_res_valid         = 1'b1;
            n_state             = S_IDLE;
        end

        if (i_clear) begin
            n_qhead = '0;
            n_qtail = '0;
            n_qfill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qhead     <= '0;
            r_qtail     <= '0;
            r_qfill     <= '0;
            r_sfill     <= '0;
            r_drop      <= '0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qhead     <= n_qhead;
            r_qtail     <= n_qtail;
            r_qfill     <= n_qfill;
            r_sfill     <= n_sfill;
            r_drop      <= n_drop;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule
